@@ sv/aabb_collision_resolver_core_defines.svh @@
// Assertion macros used by the collision resolver top level.
`ifndef AABB_COLLISION_RESOLVER_CORE_DEFINES_SVH
`define AABB_COLLISION_RESOLVER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AABBCR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aabbcr assertion failed");

// Next-cycle implication, disabled during reset.
`define AABBCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aabbcr assertion failed");

`endif

@@ sv/aabbcr_pkg.sv @@
// Types, constants and helper functions for the collision resolver.
package aabbcr_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int FIELD_W     = 16;
   localparam int SIZE_W      = 15;
   localparam int ID_W        = 16;
   localparam int MAX_W       = (COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W;
   localparam int EXT_W       = MAX_W + 3;

   localparam logic signed [EXT_W-1:0] COORD_MAX =
      {{(EXT_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [EXT_W-1:0] COORD_MIN = ~COORD_MAX;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [FIELD_W-1:0]     field_type;
   typedef logic        [SIZE_W-1:0]      size_type;
   typedef logic        [ID_W-1:0]        id_type;
   typedef logic signed [EXT_W-1:0]       ext_type;

   typedef enum logic {
      CMD_START    = 1'b0,
      CMD_OBSTACLE = 1'b1
   } aabbcr_cmd_type;

   typedef struct packed {
      aabbcr_cmd_type command;
      field_type      pos_x;
      field_type      pos_y;
      size_type       size_w;
      size_type       size_h;
      field_type      vel_x;
      field_type      vel_y;
      id_type         body_id;
      logic           stationary;
   } aabbcr_item_type;

   typedef struct packed {
      coord_type cur_x;
      coord_type cur_y;
      field_type cur_vx;
      field_type cur_vy;
      size_type  mover_w;
      size_type  mover_h;
      id_type    mover_id;
      logic      is_stationary;
      logic      landed;
   } aabbcr_state_type;

   typedef struct packed {
      field_type out_x;
      field_type out_y;
      field_type out_vel_x;
      field_type out_vel_y;
      logic      floored;
   } aabbcr_rsp_type;

   localparam aabbcr_state_type STATE_RESET = '{
      cur_x: '0, cur_y: '0, cur_vx: '0, cur_vy: '0, mover_w: '0, mover_h: '0,
      mover_id: '0, is_stationary: 1'b1, landed: 1'b0};

   function automatic ext_type ext_coord(coord_type v);
      return EXT_W'(v);
   endfunction

   function automatic ext_type ext_field(field_type v);
      return EXT_W'(v);
   endfunction

   function automatic ext_type ext_size(size_type v);
      return ext_type'({{(EXT_W-SIZE_W){1'b0}}, v});
   endfunction

   function automatic coord_type sat_coord(ext_type v);
      coord_type r;
      if (v > COORD_MAX) begin
         r = COORD_MAX[COORD_WIDTH-1:0];
      end else if (v < COORD_MIN) begin
         r = COORD_MIN[COORD_WIDTH-1:0];
      end else begin
         r = v[COORD_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic field_type coord_to_field(coord_type v);
      ext_type e;
      e = ext_coord(v);
      return e[FIELD_W-1:0];
   endfunction

endpackage

@@ sv/aabbcr_channels.sv @@
// Valid/ready channel interfaces for the resolver's item and result streams.
interface aabbcr_req_if
   import aabbcr_pkg::*;
   ();
   logic           valid;
   logic           ready;
   aabbcr_cmd_type command;
   field_type      pos_x;
   field_type      pos_y;
   size_type       size_w;
   size_type       size_h;
   field_type      vel_x;
   field_type      vel_y;
   id_type         body_id;
   logic           stationary;

   modport source (output valid, command, pos_x, pos_y, size_w, size_h, vel_x, vel_y,
                   body_id, stationary, input ready);
   modport sink (input valid, command, pos_x, pos_y, size_w, size_h, vel_x, vel_y,
                 body_id, stationary, output ready);
endinterface

interface aabbcr_rsp_if
   import aabbcr_pkg::*;
   ();
   logic      valid;
   logic      ready;
   field_type out_x;
   field_type out_y;
   field_type out_vel_x;
   field_type out_vel_y;
   logic      floored;

   modport source (output valid, out_x, out_y, out_vel_x, out_vel_y, floored,
                   input ready);
   modport sink (input valid, out_x, out_y, out_vel_x, out_vel_y, floored,
                 output ready);
endinterface

@@ sv/aabbcr_in_stage.sv @@
// Input register stage: captures one item and holds it until the datapath takes it.
module aabbcr_in_stage
   import aabbcr_pkg::*;
   (
   input  logic            clock,
   input  logic            reset,
   aabbcr_req_if.sink      req_chan,
   input  logic            advance,
   output logic            item_valid,
   output aabbcr_item_type item
   );

   logic            in_v_ff, in_v_in;
   aabbcr_item_type item_ff, item_in;
   logic            accept;

   assign req_chan.ready = !in_v_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in = item_ff;
      in_v_in = in_v_ff;
      if (accept) begin
         in_v_in            = 1'b1;
         item_in.command    = req_chan.command;
         item_in.pos_x      = req_chan.pos_x;
         item_in.pos_y      = req_chan.pos_y;
         item_in.size_w     = req_chan.size_w;
         item_in.size_h     = req_chan.size_h;
         item_in.vel_x      = req_chan.vel_x;
         item_in.vel_y      = req_chan.vel_y;
         item_in.body_id    = req_chan.body_id;
         item_in.stationary = req_chan.stationary;
      end else if (advance) begin
         in_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = in_v_ff;
   assign item       = item_ff;

endmodule

@@ sv/aabbcr_resolve.sv @@
// Next mover state for one item: load on start, overlap test and push on obstacle.
module aabbcr_resolve
   import aabbcr_pkg::*;
   (
   input  aabbcr_item_type  item,
   input  aabbcr_state_type state,
   output aabbcr_state_type next_state
   );

   ext_type x, y, w, h, vx, vy, px, py, sw, sh;
   logic    overlap, hit;

   always_comb begin
      x  = ext_coord(state.cur_x);
      y  = ext_coord(state.cur_y);
      w  = ext_size(state.mover_w);
      h  = ext_size(state.mover_h);
      vx = ext_field(state.cur_vx);
      vy = ext_field(state.cur_vy);
      px = ext_field(item.pos_x);
      py = ext_field(item.pos_y);
      sw = ext_size(item.size_w);
      sh = ext_size(item.size_h);

      overlap = (x < px + sw) && (x + w > px) && (y < py + sh) && (y + h > py);
      hit     = (item.command == CMD_OBSTACLE) && !state.is_stationary &&
                (item.body_id != state.mover_id) && overlap;

      next_state = state;
      if (item.command == CMD_START) begin
         next_state.cur_x         = sat_coord(px);
         next_state.cur_y         = sat_coord(py);
         next_state.cur_vx        = item.vel_x;
         next_state.cur_vy        = item.vel_y;
         next_state.mover_w       = item.size_w;
         next_state.mover_h       = item.size_h;
         next_state.mover_id      = item.body_id;
         next_state.is_stationary = item.stationary;
         next_state.landed        = 1'b0;
      end else if (hit) begin
         priority if (x + w - vx - ext_type'(1) < px) begin
            next_state.cur_x  = sat_coord(px - w);
            next_state.cur_vx = '0;
         end else if (px + sw - ext_type'(1) < x - vx) begin
            next_state.cur_x  = sat_coord(px + sw);
            next_state.cur_vx = '0;
         end else if (y - vy < py) begin
            next_state.cur_y  = sat_coord(py - h);
            next_state.cur_vy = '0;
            next_state.landed = 1'b1;
         end else begin
            next_state.cur_y  = sat_coord(py + sh);
            next_state.cur_vy = '0;
         end
      end
   end

endmodule

@@ sv/aabb_collision_resolver_core.sv @@
// Top level of the axis-aligned box collision resolver.
// Usage:
//   req_chan carries items: a start item (command 0) loads the mover's position,
//   size, velocity, id and stationary flag and clears floored; each following
//   obstacle item (command 1) is checked against the running mover position and
//   pushes a non-stationary mover with another id out of the box on overlap.
//   rsp_chan returns one result per item: mover position, velocity and floored
//   as they stand after that item.
// Pipeline: the accepting edge loads the input register, and the mover state and
//   result register load from it once the result register is empty or being taken.
// Throughput: 1 item per cycle unless rsp_chan stalls; the mover state updates in
//   the same cycle the result register loads, so dependent obstacles follow at once.
// Reset: synchronous, active high; clears both stages and sets the mover to
//   stationary at the origin, so obstacles before a start leave it unchanged.
// Stall: when rsp_chan.ready is low the result holds; one more item waits in the
//   input register, then req_chan.ready drops until the result is taken.
module aabb_collision_resolver_core
   import aabbcr_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   aabbcr_req_if.sink  req_chan,
   aabbcr_rsp_if.source rsp_chan
   );

`include "aabb_collision_resolver_core_defines.svh"

   aabbcr_item_type  item;
   logic             item_valid;
   logic             advance;
   aabbcr_state_type state_ff, state_in, next_state;
   aabbcr_rsp_type   rsp_ff, rsp_in;
   logic             out_v_ff, out_v_in;

   aabbcr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   aabbcr_resolve u_resolve (
      .item       (item),
      .state      (state_ff),
      .next_state (next_state)
   );

   assign advance = item_valid && (!out_v_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      rsp_in   = rsp_ff;
      out_v_in = out_v_ff;
      if (advance) begin
         state_in         = next_state;
         out_v_in         = 1'b1;
         rsp_in.out_x     = coord_to_field(next_state.cur_x);
         rsp_in.out_y     = coord_to_field(next_state.cur_y);
         rsp_in.out_vel_x = next_state.cur_vx;
         rsp_in.out_vel_y = next_state.cur_vy;
         rsp_in.floored   = next_state.landed;
      end else if (rsp_chan.ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid     = out_v_ff;
   assign rsp_chan.out_x     = rsp_ff.out_x;
   assign rsp_chan.out_y     = rsp_ff.out_y;
   assign rsp_chan.out_vel_x = rsp_ff.out_vel_x;
   assign rsp_chan.out_vel_y = rsp_ff.out_vel_y;
   assign rsp_chan.floored   = rsp_ff.floored;

   `AABBCR_ASSERT_NOW(a_ready_when_empty, clock, reset, !out_v_ff, req_chan.ready)
   `AABBCR_ASSERT_NOW(a_floored_tracks_state, clock, reset, out_v_ff,
      rsp_chan.floored == state_ff.landed)
   `AABBCR_ASSERT_NEXT(a_start_clears_floored, clock, reset,
      advance && item.command == CMD_START, !state_ff.landed)
   `AABBCR_ASSERT_NEXT(a_stationary_holds, clock, reset,
      advance && item.command == CMD_OBSTACLE && state_ff.is_stationary,
      $stable(state_ff))

endmodule
